@@ design/mav_pkg.sv @@
package mav_pkg;

    localparam int MAX_WINDOW_DEF = 64;
    localparam int SAMPLE_WIDTH_DEF = 16;

    localparam int WIN_W = 7;
    localparam logic [WIN_W-1:0] WIN_RESET = 7'd64;

    function automatic int addr_width(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

@@ design/moving_average_filter.sv @@
// Moving average filter over the last window_size samples.
// Input channel: sample with sample_valid / sample_stall. A transfer happens on a
// rising edge with sample_valid high and sample_stall low. Output channel: average
// with average_valid / average_stall, one result per input sample.
// window_size is written through window_size_we; the user must write it only while
// the filter is idle, and the filter does not enforce this. Zero acts as one and
// values above MAX_WINDOW act as MAX_WINDOW. Reset value is 64. A sample is not
// taken until the one before it has passed the update, start, divide and output
// states. The divider yields one quotient bit per cycle over the SUMW-bit sum,
// where SUMW = SAMPLE_WIDTH + log2(MAX_WINDOW).
// A finished result sits in an output register, so the next sample is taken while
// it waits. If the receiver stalls and a second result is ready, the sequencer
// holds it and keeps sample_stall high until the output register frees up.
// Reset clears the running sum, the write position, the fill count and the count
// of written ring entries; ring entries never written read as zero, so no clearing
// pass is needed and the filter is ready right after reset.
module moving_average_filter #(
    parameter int MAX_WINDOW   = mav_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_WIDTH = mav_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           window_size_we,
    input  logic [mav_pkg::WIN_W-1:0]      window_size,
    input  logic                           sample_valid,
    output logic                           sample_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    output logic                           average_valid,
    input  logic                           average_stall,
    output logic signed [SAMPLE_WIDTH-1:0] average
);

    localparam int SW   = SAMPLE_WIDTH;
    localparam int PW   = mav_pkg::addr_width(MAX_WINDOW);
    localparam int CW   = $clog2(MAX_WINDOW + 1);
    localparam int SUMW = SW + PW;
    localparam int CMPW = (CW > mav_pkg::WIN_W) ? CW : mav_pkg::WIN_W;

    localparam logic [SUMW-1:0] MAG_MAX = {{(PW + 1){1'b0}}, {(SW - 1){1'b1}}};
    localparam logic [SUMW-1:0] MAG_MIN = MAG_MAX + SUMW'(1);
    localparam logic [SW-1:0]   AVG_MAX = {1'b0, {(SW - 1){1'b1}}};
    localparam logic [SW-1:0]   AVG_MIN = {1'b1, {(SW - 1){1'b0}}};

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_UPDATE = 3'd1;
    localparam logic [2:0] S_START  = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_OUT    = 3'd4;

    logic [2:0]                state_reg;
    logic [2:0]                state_next;
    logic [mav_pkg::WIN_W-1:0] win_reg;
    logic [mav_pkg::WIN_W-1:0] win_next;
    logic [SW-1:0]             sample_reg;
    logic [SW-1:0]             sample_next;
    logic signed [SUMW-1:0]    sum_reg;
    logic signed [SUMW-1:0]    sum_next;
    logic [PW-1:0]             pos_reg;
    logic [PW-1:0]             pos_next;
    logic [CW-1:0]             hwm_reg;
    logic [CW-1:0]             hwm_next;
    logic [CW-1:0]             fill_reg;
    logic [CW-1:0]             fill_next;
    logic                      neg_reg;
    logic                      neg_next;
    logic [SUMW-1:0]           mag_reg;
    logic [SUMW-1:0]           mag_next;
    logic                      avg_valid_reg;
    logic                      avg_valid_next;
    logic [SW-1:0]             avg_reg;
    logic [SW-1:0]             avg_next;

    logic                      in_xfer;
    logic                      out_free;
    logic [CMPW-1:0]           win_ext;
    logic [CW-1:0]             eff_win;
    logic [CW-1:0]             pos_inc;
    logic                      old_written;
    logic [SW-1:0]             ram_rdata;
    logic                      ram_we;
    logic                      div_start;
    logic                      div_done;
    logic [SUMW-1:0]           div_quot;
    logic signed [SUMW-1:0]    old_ext;
    logic signed [SUMW-1:0]    new_ext;
    logic signed [SUMW-1:0]    sum_upd;
    logic [SUMW-1:0]           quot_neg;
    logic [SW-1:0]             avg_sat;

    assign in_xfer  = sample_valid && !sample_stall;
    assign out_free = !avg_valid_reg || !average_stall;

    always_comb
    begin
        win_ext = CMPW'(win_reg);
        if (win_reg == '0)
        begin
            eff_win = CW'(1);
        end
        else if (win_ext > CMPW'(MAX_WINDOW))
        begin
            eff_win = CW'(MAX_WINDOW);
        end
        else
        begin
            eff_win = CW'(win_ext);
        end
    end

    assign pos_inc     = CW'(pos_reg) + CW'(1);
    assign old_written = (CW'(pos_reg) < hwm_reg);
    assign old_ext     = old_written ? {{PW{ram_rdata[SW-1]}}, ram_rdata} : '0;
    assign new_ext     = {{PW{sample_reg[SW-1]}}, sample_reg};
    assign sum_upd     = sum_reg - old_ext + new_ext;
    assign ram_we      = (state_reg == S_UPDATE);
    assign div_start   = (state_reg == S_START);
    assign quot_neg    = ~div_quot + SUMW'(1);

    always_comb
    begin
        if (neg_reg)
        begin
            avg_sat = (div_quot > MAG_MIN) ? AVG_MIN : quot_neg[SW-1:0];
        end
        else
        begin
            avg_sat = (div_quot > MAG_MAX) ? AVG_MAX : div_quot[SW-1:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        win_next       = window_size_we ? window_size : win_reg;
        sample_next    = sample_reg;
        sum_next       = sum_reg;
        pos_next       = pos_reg;
        hwm_next       = hwm_reg;
        fill_next      = fill_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        avg_valid_next = avg_valid_reg && average_stall;
        avg_next       = avg_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    sample_next = sample;
                    state_next  = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                sum_next = sum_upd;
                neg_next = sum_upd[SUMW-1];
                mag_next = sum_upd[SUMW-1] ? $unsigned(-sum_upd) : $unsigned(sum_upd);
                pos_next = (pos_inc >= eff_win) ? '0 : PW'(pos_inc);
                if (CW'(pos_reg) == hwm_reg)
                begin
                    hwm_next = hwm_reg + CW'(1);
                end
                if (fill_reg < eff_win)
                begin
                    fill_next = fill_reg + CW'(1);
                end
                state_next = S_START;
            end
            S_START:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    avg_valid_next = 1'b1;
                    avg_next       = avg_sat;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            win_reg       <= mav_pkg::WIN_RESET;
            sum_reg       <= '0;
            pos_reg       <= '0;
            hwm_reg       <= '0;
            fill_reg      <= '0;
            avg_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            win_reg       <= win_next;
            sum_reg       <= sum_next;
            pos_reg       <= pos_next;
            hwm_reg       <= hwm_next;
            fill_reg      <= fill_next;
            avg_valid_reg <= avg_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        neg_reg    <= neg_next;
        mag_reg    <= mag_next;
        avg_reg    <= avg_next;
    end

    mav_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pos_reg),
        .wdata (sample_reg),
        .re    (in_xfer),
        .raddr (pos_reg),
        .rdata (ram_rdata)
    );

    mav_div #(
        .DW (SUMW),
        .VW (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mag_reg),
        .divisor  (fill_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign sample_stall  = (state_reg != S_IDLE);
    assign average_valid = avg_valid_reg;
    assign average       = avg_reg;

    // The write position never runs ahead of the written part of the ring.
    assert property (@(posedge clk) disable iff (!rst_n)
        (CW'(pos_reg) < hwm_reg) || (CW'(pos_reg) == hwm_reg))
        else $error("write position beyond written ring entries");

    // The divider never sees a zero fill count.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (fill_reg != '0))
        else $error("divide started with zero fill count");

    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside the divide state");

    // A pending result is not dropped while the output register is occupied.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && !out_free) |=> (state_reg == S_OUT) && average_valid)
        else $error("finished result lost while output stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == S_UPDATE))
        else $error("accepted sample not processed");

endmodule

@@ design/mav_ram.sv @@
module mav_ram #(
    parameter int WIDTH = mav_pkg::SAMPLE_WIDTH_DEF,
    parameter int DEPTH = mav_pkg::MAX_WINDOW_DEF
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [mav_pkg::addr_width(DEPTH)-1:0]   waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [mav_pkg::addr_width(DEPTH)-1:0]   raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ design/mav_div.sv @@
module mav_div #(
    parameter int DW = 22,
    parameter int VW = 7
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);

    localparam int CNT_W = $clog2(DW + 1);

    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [DW-1:0]    work_reg;
    logic [DW-1:0]    work_next;
    logic [VW-1:0]    rem_reg;
    logic [VW-1:0]    rem_next;
    logic [VW-1:0]    div_reg;
    logic [VW-1:0]    div_next;
    logic [VW:0]      trial;
    logic [VW:0]      diff;
    logic             ge;

    // One quotient bit per cycle by restoring division.
    always_comb
    begin
        trial     = {rem_reg, work_reg[DW-1]};
        diff      = trial - {1'b0, div_reg};
        ge        = (trial >= {1'b0, div_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        work_next = work_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DW);
            work_next = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[VW-1:0] : trial[VW-1:0];
            work_next = {work_reg[DW-2:0], ge};
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
    end

    assign done     = done_reg;
    assign quotient = work_reg;

endmodule

@@ test/tb_moving_average_filter.sv @@
`timescale 1ns / 1ps

module tb_moving_average_filter;

    localparam int SW          = mav_pkg::SAMPLE_WIDTH_DEF;
    localparam int DEPTH       = mav_pkg::MAX_WINDOW_DEF;
    localparam int WW          = mav_pkg::WIN_W;
    localparam int SAMPLE_MAX  = (1 <<< (SW - 1)) - 1;
    localparam int SAMPLE_MIN  = -SAMPLE_MAX - 1;
    localparam int ITEM_TARGET = 850;
    localparam int SETTLE      = 40;
    localparam int CYCLE_LIMIT = 1000000;

    typedef logic signed [SW-1:0] sample_t;
    typedef logic [WW-1:0] window_t;

    typedef enum int {
        MIX_UNIFORM,
        MIX_EDGES,
        MIX_SMALL,
        MIX_HIGH,
        MIX_LOW
    } sample_mix_t;

    class average_scoreboard;
        sample_t history [DEPTH];
        int      total;
        int      slot;
        int      count;
        window_t window_reg;
        sample_t expected_averages [$];
        int      errors;

        function new();
            foreach (history[i])
                history[i] = '0;
            total      = 0;
            slot       = 0;
            count      = 0;
            window_reg = mav_pkg::WIN_RESET;
            errors     = 0;
        endfunction

        function void set_window(window_t value);
            window_reg = value;
        endfunction

        function int pending();
            return expected_averages.size();
        endfunction

        function void note_sample(sample_t value);
            int span;
            int quotient;
            if (window_reg == 0)
                span = 1;
            else if (window_reg > DEPTH)
                span = DEPTH;
            else
                span = window_reg;
            if (slot >= DEPTH)
                slot = 0;
            total = total - history[slot] + value;
            history[slot] = value;
            slot++;
            if (slot >= span)
                slot = 0;
            if (count < span)
                count++;
            quotient = total / count;
            if (quotient > SAMPLE_MAX)
                quotient = SAMPLE_MAX;
            if (quotient < SAMPLE_MIN)
                quotient = SAMPLE_MIN;
            expected_averages.push_back(sample_t'(quotient));
        endfunction

        task report(string msg);
            $display("%0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_average(sample_t got);
            sample_t want;
            if (expected_averages.size() == 0)
            begin
                report($sformatf("average %0d with no transfer pending", got));
            end
            else
            begin
                want = expected_averages.pop_front();
                if (got !== want)
                    report($sformatf("average mismatch: got %0d, expected %0d", got, want));
            end
        endtask
    endclass

    logic    clk            = 1'b0;
    logic    rst_n          = 1'b0;
    logic    window_size_we = 1'b0;
    window_t window_size    = '0;
    logic    sample_valid   = 1'b0;
    logic    sample_stall;
    sample_t sample         = '0;
    logic    average_valid;
    logic    average_stall  = 1'b0;
    sample_t average;

    average_scoreboard sb;
    bit calm = 1'b0;
    int samples_sent = 0;
    int cycle_count = 0;

    moving_average_filter dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .window_size_we (window_size_we),
        .window_size    (window_size),
        .sample_valid   (sample_valid),
        .sample_stall   (sample_stall),
        .sample         (sample),
        .average_valid  (average_valid),
        .average_stall  (average_stall),
        .average        (average)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(negedge clk)
        average_stall <= calm ? 1'b0 : ($urandom_range(99) < 30);

    always @(posedge clk)
        if (rst_n && average_valid && !average_stall)
            sb.check_average(average);

    function automatic sample_t pick_sample(sample_mix_t mix);
        case (mix)
            MIX_EDGES:
                case ($urandom_range(4))
                    0: return sample_t'(SAMPLE_MAX);
                    1: return sample_t'(SAMPLE_MIN);
                    2: return '0;
                    3: return '1;
                    default: return sample_t'($urandom);
                endcase
            MIX_SMALL: return sample_t'(int'($urandom_range(200)) - 100);
            MIX_HIGH: return sample_t'($urandom_range(SAMPLE_MAX, SAMPLE_MAX / 2));
            MIX_LOW: return sample_t'(SAMPLE_MIN + int'($urandom_range(SAMPLE_MAX / 2)));
            default: return sample_t'($urandom);
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer
    // with sample_valid still high.
    task send_sample(sample_t value);
        if (!calm && $urandom_range(99) < 30)
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(40, 1)) @(negedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= value;
        do
            @(posedge clk);
        while (sample_stall);
        sb.note_sample(value);
        samples_sent++;
        @(negedge clk);
    endtask

    task write_window(window_t value);
        sample_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        window_size_we <= 1'b1;
        window_size    <= value;
        @(negedge clk);
        sb.set_window(value);
        window_size_we <= 1'b0;
        window_size    <= window_t'($urandom);
    endtask

    task run_phase(window_t value, int items, sample_mix_t mix);
        write_window(value);
        repeat (items)
        begin
            calm = (samples_sent >= 300 && samples_sent < 450);
            send_sample(pick_sample(mix));
        end
    endtask

    initial
    begin
        window_t     next_window;
        int          items;
        sample_mix_t mix;

        sb = new();
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Fill count lags the ring after the shrink, so the quotient saturates low.
        send_sample(sample_t'(SAMPLE_MIN));
        send_sample(sample_t'(SAMPLE_MIN));
        write_window(window_t'(1));
        send_sample(sample_t'(SAMPLE_MIN));
        send_sample(sample_t'(SAMPLE_MAX));
        write_window('0);
        send_sample(sample_t'(SAMPLE_MAX));
        send_sample('1);
        write_window('1);
        send_sample('0);
        send_sample('1);
        send_sample(sample_t'(1));
        send_sample(sample_t'(16'h5555));
        send_sample(sample_t'(16'haaaa));
        send_sample(sample_t'(SAMPLE_MAX));
        send_sample(sample_t'(SAMPLE_MIN));
        send_sample(sample_t'(SAMPLE_MAX));

        while (samples_sent < ITEM_TARGET)
        begin
            case ($urandom_range(5))
                0: next_window = window_t'(1);
                1: next_window = window_t'(DEPTH);
                2: next_window = '0;
                3: next_window = '1;
                4: next_window = window_t'($urandom_range(DEPTH, 1));
                default: next_window = window_t'($urandom);
            endcase
            items = ($urandom_range(9) == 0) ? $urandom_range(150, 60) : $urandom_range(60, 5);
            if (items > ITEM_TARGET - samples_sent)
                items = ITEM_TARGET - samples_sent;
            mix = sample_mix_t'($urandom_range(MIX_LOW, MIX_UNIFORM));
            run_phase(next_window, items, mix);
        end

        calm = 1'b0;
        sample_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);

        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
